@@ rtl/rfec_pkg.sv @@
// ----------------------------------------------------------------------------
// rfec_pkg: receiver front-end chain shared definitions
// Field widths, configuration register indexes, datapath command codes and
// the rounding and saturation helpers used by the sequenced datapath.
// ----------------------------------------------------------------------------
package rfec_pkg;

  localparam int WAVE_W     = 16;
  localparam int NOISE_W    = 16;
  localparam int OUT_W      = 24;
  localparam int GAIN_W     = 16;
  localparam int COEF_W     = 18;
  localparam int B1_W       = 20;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 18;
  localparam int ACC_W      = 48;
  localparam int MUL_A_W    = 25;
  localparam int MUL_B_W    = 28;
  localparam int M_W        = 18;

  // amplifier noise voltage in units of 2^-15
  localparam int AMP_NOISE_LSB = 16;
  // 0.3 as 19661/2^16, folded with the amplifier noise voltage
  localparam int AMP_NZ_MUL    = AMP_NOISE_LSB * 19661;
  // 0.8 as 52429/2^16
  localparam int LEVEL_SCALE   = 52429;
  localparam int ONE_Q15       = 32768;
  localparam int B1_ONE        = 65536;
  localparam int OFS_SHIFT     = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OPTICAL_MODE = 4'd0,
    REG_TIA_SIG_GAIN = 4'd1,
    REG_TIA_NZ_GAIN  = 4'd2,
    REG_TIA_FEED     = 4'd3,
    REG_TIA_BACK     = 4'd4,
    REG_AMP_GAIN     = 4'd5,
    REG_PEAK_FEED    = 4'd6,
    REG_PEAK_BACK    = 4'd7
  } reg_idx_e;

  typedef struct packed {
    logic                      optical_mode;
    logic [GAIN_W-1:0]         tia_signal_gain;
    logic [GAIN_W-1:0]         tia_noise_gain;
    logic signed [COEF_W-1:0]  tia_b0;
    logic signed [COEF_W-1:0]  tia_a1;
    logic signed [B1_W-1:0]    tia_b1;
    logic [GAIN_W-1:0]         amp_gain;
    logic signed [COEF_W-1:0]  peak_b0;
    logic signed [COEF_W-1:0]  peak_a1;
    logic signed [B1_W-1:0]    peak_b1;
  } cfg_t;

  typedef enum logic [3:0] {
    MUL_NONE    = 4'd0,
    MUL_N_AMP03 = 4'd1,
    MUL_X_08    = 4'd2,
    MUL_N_AMP   = 4'd3,
    MUL_GN_N    = 4'd4,
    MUL_GS_M    = 4'd5,
    MUL_TB1     = 4'd6,
    MUL_TB0     = 4'd7,
    MUL_TA1     = 4'd8,
    MUL_AG      = 4'd9,
    MUL_PB1     = 4'd10,
    MUL_PB0     = 4'd11,
    MUL_PA1     = 4'd12
  } mul_sel_e;

  typedef enum logic [3:0] {
    OP_NONE = 4'd0,
    OP_NZ   = 4'd1,
    OP_EL   = 4'd2,
    OP_M    = 4'd3,
    OP_TN   = 4'd4,
    OP_TV   = 4'd5,
    OP_LOAD = 4'd6,
    OP_ADD  = 4'd7,
    OP_SUB  = 4'd8,
    OP_TOUT = 4'd9,
    OP_OFS  = 4'd10,
    OP_AMPU = 4'd11,
    OP_AR   = 4'd12,
    OP_POUT = 4'd13
  } dp_op_e;

  typedef struct packed {
    logic     capture;
    mul_sel_e mul_sel;
    dp_op_e   op;
  } dp_cmd_t;

  typedef struct packed {
    logic optical;
    logic out_stall;
  } dp_sts_t;

  // round half up, then arithmetic shift right by s
  function automatic logic signed [ACC_W-1:0] rnd_shr(logic signed [ACC_W-1:0] v,
                                                      int unsigned s);
    logic signed [ACC_W-1:0] half;
    half = ACC_W'(1) << (s - 1);
    return (v + half) >>> s;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat24(logic signed [ACC_W-1:0] v);
    logic all_same;
    all_same = (v[ACC_W-1:OUT_W-1] == '0) || (v[ACC_W-1:OUT_W-1] == '1);
    if (all_same) begin
      return v[OUT_W-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      return {1'b0, {(OUT_W-1){1'b1}}};
    end
  endfunction

endpackage

@@ rtl/rfec_if.sv @@
// ----------------------------------------------------------------------------
// rfec_if: receiver front-end chain channel interfaces
// Sample input, result output and configuration write channels, each a
// valid/ready pair with its payload.
// ----------------------------------------------------------------------------
interface rfec_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [rfec_pkg::WAVE_W-1:0]  wave_sample;
  logic signed [rfec_pkg::NOISE_W-1:0] noise_sample;

  modport source (output valid, output wave_sample, output noise_sample, input ready);
  modport sink   (input valid, input wave_sample, input noise_sample, output ready);
endinterface

interface rfec_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [rfec_pkg::OUT_W-1:0] front_end_out;

  modport source (output valid, output front_end_out, input ready);
  modport sink   (input valid, input front_end_out, output ready);
endinterface

interface rfec_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rfec_pkg::CFG_IDX_W-1:0]  index;
  logic [rfec_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/rfec_regs.sv @@
// ----------------------------------------------------------------------------
// rfec_regs: configuration register file
// Holds the mode, gains and filter coefficients; keeps each section's b1
// coefficient as 1 + a1 - b0, updated whenever b0 or a1 is written.
// ----------------------------------------------------------------------------
module rfec_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  rfec_cfg_if.sink       cfg_i,
  output rfec_pkg::cfg_t cfg_o
);

  rfec_pkg::cfg_t                          cfg_q;
  logic signed [rfec_pkg::COEF_W-1:0]      wr_coef;

  assign cfg_i.ready = 1'b1;
  assign wr_coef     = signed'(cfg_i.data[rfec_pkg::COEF_W-1:0]);
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.optical_mode    <= 1'b0;
      cfg_q.tia_signal_gain <= rfec_pkg::GAIN_W'(256);
      cfg_q.tia_noise_gain  <= '0;
      cfg_q.tia_b0          <= rfec_pkg::COEF_W'(65536);
      cfg_q.tia_a1          <= '0;
      cfg_q.tia_b1          <= '0;
      cfg_q.amp_gain        <= rfec_pkg::GAIN_W'(256);
      cfg_q.peak_b0         <= rfec_pkg::COEF_W'(65536);
      cfg_q.peak_a1         <= '0;
      cfg_q.peak_b1         <= '0;
    end else if (cfg_i.valid) begin
      case (rfec_pkg::reg_idx_e'(cfg_i.index))
        rfec_pkg::REG_OPTICAL_MODE: cfg_q.optical_mode <= cfg_i.data[0];
        rfec_pkg::REG_TIA_SIG_GAIN:
          cfg_q.tia_signal_gain <= cfg_i.data[rfec_pkg::GAIN_W-1:0];
        rfec_pkg::REG_TIA_NZ_GAIN:
          cfg_q.tia_noise_gain <= cfg_i.data[rfec_pkg::GAIN_W-1:0];
        rfec_pkg::REG_TIA_FEED: begin
          cfg_q.tia_b0 <= wr_coef;
          cfg_q.tia_b1 <= rfec_pkg::B1_W'(rfec_pkg::B1_ONE) + rfec_pkg::B1_W'(cfg_q.tia_a1)
                          - rfec_pkg::B1_W'(wr_coef);
        end
        rfec_pkg::REG_TIA_BACK: begin
          cfg_q.tia_a1 <= wr_coef;
          cfg_q.tia_b1 <= rfec_pkg::B1_W'(rfec_pkg::B1_ONE) + rfec_pkg::B1_W'(wr_coef)
                          - rfec_pkg::B1_W'(cfg_q.tia_b0);
        end
        rfec_pkg::REG_AMP_GAIN: cfg_q.amp_gain <= cfg_i.data[rfec_pkg::GAIN_W-1:0];
        rfec_pkg::REG_PEAK_FEED: begin
          cfg_q.peak_b0 <= wr_coef;
          cfg_q.peak_b1 <= rfec_pkg::B1_W'(rfec_pkg::B1_ONE) + rfec_pkg::B1_W'(cfg_q.peak_a1)
                           - rfec_pkg::B1_W'(wr_coef);
        end
        rfec_pkg::REG_PEAK_BACK: begin
          cfg_q.peak_a1 <= wr_coef;
          cfg_q.peak_b1 <= rfec_pkg::B1_W'(rfec_pkg::B1_ONE) + rfec_pkg::B1_W'(wr_coef)
                           - rfec_pkg::B1_W'(cfg_q.peak_b0);
        end
        default: ;
      endcase
    end
  end

  a_tia_b1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_q.tia_b1 == rfec_pkg::B1_W'(rfec_pkg::B1_ONE) + rfec_pkg::B1_W'(cfg_q.tia_a1)
                    - rfec_pkg::B1_W'(cfg_q.tia_b0))
    else $error("tia b1 out of step with b0/a1");

  a_peak_b1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_q.peak_b1 == rfec_pkg::B1_W'(rfec_pkg::B1_ONE) + rfec_pkg::B1_W'(cfg_q.peak_a1)
                     - rfec_pkg::B1_W'(cfg_q.peak_b0))
    else $error("peak b1 out of step with b0/a1");

endmodule

@@ rtl/rfec_ctrl.sv @@
// ----------------------------------------------------------------------------
// rfec_ctrl: receiver front-end chain sequencer
// Steps one sample through the shared multiplier: picks the multiplier
// operands and the post-multiply operation for every cycle of the schedule.
// ----------------------------------------------------------------------------
module rfec_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rfec_pkg::dp_sts_t sts_i,
  output rfec_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [18:0] {
    S_IDLE = 19'h00001,
    S_NZ   = 19'h00002,
    S_MW   = 19'h00004,
    S_EL   = 19'h00008,
    S_GN   = 19'h00010,
    S_GS   = 19'h00020,
    S_TB1  = 19'h00040,
    S_TB0  = 19'h00080,
    S_TA1  = 19'h00100,
    S_TSUM = 19'h00200,
    S_TOUT = 19'h00400,
    S_OFS  = 19'h00800,
    S_AMPU = 19'h01000,
    S_AG   = 19'h02000,
    S_AR   = 19'h04000,
    S_PB0  = 19'h08000,
    S_PA1  = 19'h10000,
    S_PSUM = 19'h20000,
    S_POUT = 19'h40000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d       = state_q;
    cmd_o.capture = 1'b0;
    cmd_o.mul_sel = rfec_pkg::MUL_NONE;
    cmd_o.op      = rfec_pkg::OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_NZ;
        end
      end
      S_NZ: begin
        cmd_o.mul_sel = rfec_pkg::MUL_N_AMP03;
        state_d       = S_MW;
      end
      S_MW: begin
        cmd_o.op = rfec_pkg::OP_NZ;
        if (sts_i.optical) begin
          cmd_o.mul_sel = rfec_pkg::MUL_X_08;
          state_d       = S_GN;
        end else begin
          cmd_o.mul_sel = rfec_pkg::MUL_N_AMP;
          state_d       = S_EL;
        end
      end
      S_EL: begin
        cmd_o.op = rfec_pkg::OP_EL;
        state_d  = S_AMPU;
      end
      S_GN: begin
        cmd_o.mul_sel = rfec_pkg::MUL_GN_N;
        cmd_o.op      = rfec_pkg::OP_M;
        state_d       = S_GS;
      end
      S_GS: begin
        cmd_o.mul_sel = rfec_pkg::MUL_GS_M;
        cmd_o.op      = rfec_pkg::OP_TN;
        state_d       = S_TB1;
      end
      S_TB1: begin
        cmd_o.mul_sel = rfec_pkg::MUL_TB1;
        cmd_o.op      = rfec_pkg::OP_TV;
        state_d       = S_TB0;
      end
      S_TB0: begin
        cmd_o.mul_sel = rfec_pkg::MUL_TB0;
        cmd_o.op      = rfec_pkg::OP_LOAD;
        state_d       = S_TA1;
      end
      S_TA1: begin
        cmd_o.mul_sel = rfec_pkg::MUL_TA1;
        cmd_o.op      = rfec_pkg::OP_ADD;
        state_d       = S_TSUM;
      end
      S_TSUM: begin
        cmd_o.op = rfec_pkg::OP_SUB;
        state_d  = S_TOUT;
      end
      S_TOUT: begin
        cmd_o.op = rfec_pkg::OP_TOUT;
        state_d  = S_OFS;
      end
      S_OFS: begin
        cmd_o.op = rfec_pkg::OP_OFS;
        state_d  = S_AMPU;
      end
      S_AMPU: begin
        cmd_o.op = rfec_pkg::OP_AMPU;
        state_d  = S_AG;
      end
      S_AG: begin
        cmd_o.mul_sel = rfec_pkg::MUL_AG;
        state_d       = S_AR;
      end
      S_AR: begin
        cmd_o.mul_sel = rfec_pkg::MUL_PB1;
        cmd_o.op      = rfec_pkg::OP_AR;
        state_d       = S_PB0;
      end
      S_PB0: begin
        cmd_o.mul_sel = rfec_pkg::MUL_PB0;
        cmd_o.op      = rfec_pkg::OP_LOAD;
        state_d       = S_PA1;
      end
      S_PA1: begin
        cmd_o.mul_sel = rfec_pkg::MUL_PA1;
        cmd_o.op      = rfec_pkg::OP_ADD;
        state_d       = S_PSUM;
      end
      S_PSUM: begin
        cmd_o.op = rfec_pkg::OP_SUB;
        state_d  = S_POUT;
      end
      S_POUT: begin
        // hold until the output register can take the result
        if (!sts_i.out_stall) begin
          cmd_o.op = rfec_pkg::OP_POUT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == rfec_pkg::OP_POUT |-> !sts_i.out_stall)
    else $error("result committed while output transaction pending");

  a_busy_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op != rfec_pkg::OP_NONE |-> !in_ready_o)
    else $error("input offered while datapath busy");

endmodule

@@ rtl/rfec_dp.sv @@
// ----------------------------------------------------------------------------
// rfec_dp: receiver front-end chain datapath
// One shared signed multiplier with a registered product, an accumulator,
// the low-pass and peaking section state and the output register.
// ----------------------------------------------------------------------------
module rfec_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rfec_pkg::cfg_t                      cfg_i,
  input  rfec_pkg::dp_cmd_t                   cmd_i,
  output rfec_pkg::dp_sts_t                   sts_o,
  input  logic signed [rfec_pkg::WAVE_W-1:0]  wave_sample_i,
  input  logic signed [rfec_pkg::NOISE_W-1:0] noise_sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [rfec_pkg::OUT_W-1:0]   front_end_out_o
);

  localparam int ACC_W = rfec_pkg::ACC_W;
  localparam int OUT_W = rfec_pkg::OUT_W;
  localparam int A_W   = rfec_pkg::MUL_A_W;
  localparam int B_W   = rfec_pkg::MUL_B_W;

  logic signed [rfec_pkg::WAVE_W-1:0]  x_q;
  logic signed [rfec_pkg::NOISE_W-1:0] n_q;
  logic signed [ACC_W-1:0]             p_q, acc_q, acc_d;
  logic signed [OUT_W-1:0]             v_q, v_d, nz_q, nz_d;
  logic [rfec_pkg::M_W-1:0]            m_q, m_d;
  logic signed [OUT_W-1:0]             tpx_q, tpx_d, tpy_q, tpy_d;
  logic signed [OUT_W-1:0]             ppx_q, ppx_d, ppy_q, ppy_d;
  logic signed [OUT_W-1:0]             out_q;
  logic                                out_valid_q, out_valid_d;
  logic signed [A_W-1:0]               mul_a;
  logic signed [B_W-1:0]               mul_b;
  logic signed [A_W+B_W-1:0]           prod;
  logic signed [ACC_W-1:0]             m_sum;
  logic signed [OUT_W-1:0]             sec_y;
  logic                                load_out;

  assign sts_o.optical   = cfg_i.optical_mode;
  assign sts_o.out_stall = out_valid_q && !out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign front_end_out_o = out_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_sel)
      rfec_pkg::MUL_N_AMP03: begin
        mul_a = A_W'(n_q);
        mul_b = B_W'(rfec_pkg::AMP_NZ_MUL);
      end
      rfec_pkg::MUL_X_08: begin
        mul_a = A_W'(x_q);
        mul_b = B_W'(rfec_pkg::LEVEL_SCALE);
      end
      rfec_pkg::MUL_N_AMP: begin
        mul_a = A_W'(n_q);
        mul_b = B_W'(rfec_pkg::AMP_NOISE_LSB);
      end
      rfec_pkg::MUL_GN_N: begin
        mul_a = A_W'(n_q);
        mul_b = signed'(B_W'(cfg_i.tia_noise_gain));
      end
      rfec_pkg::MUL_GS_M: begin
        mul_a = signed'(A_W'(m_q));
        mul_b = signed'(B_W'(cfg_i.tia_signal_gain));
      end
      rfec_pkg::MUL_TB1: begin
        mul_a = A_W'(tpx_q);
        mul_b = B_W'(cfg_i.tia_b1);
      end
      rfec_pkg::MUL_TB0: begin
        mul_a = A_W'(v_q);
        mul_b = B_W'(cfg_i.tia_b0);
      end
      rfec_pkg::MUL_TA1: begin
        mul_a = A_W'(tpy_q);
        mul_b = B_W'(cfg_i.tia_a1);
      end
      rfec_pkg::MUL_AG: begin
        mul_a = A_W'(v_q);
        mul_b = signed'(B_W'(cfg_i.amp_gain));
      end
      rfec_pkg::MUL_PB1: begin
        mul_a = A_W'(ppx_q);
        mul_b = B_W'(cfg_i.peak_b1);
      end
      rfec_pkg::MUL_PB0: begin
        mul_a = A_W'(v_q);
        mul_b = B_W'(cfg_i.peak_b0);
      end
      rfec_pkg::MUL_PA1: begin
        mul_a = A_W'(ppy_q);
        mul_b = B_W'(cfg_i.peak_a1);
      end
      default: ;
    endcase
  end

  assign prod  = mul_a * mul_b;
  assign m_sum = rfec_pkg::rnd_shr(p_q, 14) + ACC_W'(rfec_pkg::ONE_Q15);
  assign sec_y = rfec_pkg::sat24(rfec_pkg::rnd_shr(acc_q, 16));

  always_comb begin
    acc_d    = acc_q;
    v_d      = v_q;
    nz_d     = nz_q;
    m_d      = m_q;
    tpx_d    = tpx_q;
    tpy_d    = tpy_q;
    ppx_d    = ppx_q;
    ppy_d    = ppy_q;
    load_out = 1'b0;
    case (cmd_i.op)
      rfec_pkg::OP_NZ:   nz_d = OUT_W'(rfec_pkg::rnd_shr(p_q, 28));
      rfec_pkg::OP_EL:
        v_d = rfec_pkg::sat24((ACC_W'(x_q) <<< 2) + rfec_pkg::rnd_shr(p_q, 13));
      // clamp the detected level at zero
      rfec_pkg::OP_M:    m_d = m_sum[ACC_W-1] ? '0 : rfec_pkg::M_W'(m_sum);
      rfec_pkg::OP_TN:   acc_d = rfec_pkg::rnd_shr(p_q, 5);
      rfec_pkg::OP_TV:   v_d = rfec_pkg::sat24(acc_q + rfec_pkg::rnd_shr(p_q, 8));
      rfec_pkg::OP_LOAD: acc_d = p_q;
      rfec_pkg::OP_ADD:  acc_d = acc_q + p_q;
      rfec_pkg::OP_SUB:  acc_d = acc_q - p_q;
      rfec_pkg::OP_TOUT: begin
        tpy_d = sec_y;
        tpx_d = v_q;
      end
      rfec_pkg::OP_OFS:
        v_d = rfec_pkg::sat24(ACC_W'(tpy_q)
              - (signed'(ACC_W'(cfg_i.tia_signal_gain)) <<< rfec_pkg::OFS_SHIFT));
      rfec_pkg::OP_AMPU: v_d = rfec_pkg::sat24(ACC_W'(v_q) + ACC_W'(nz_q));
      rfec_pkg::OP_AR:   v_d = rfec_pkg::sat24(rfec_pkg::rnd_shr(p_q, 8));
      rfec_pkg::OP_POUT: begin
        ppy_d    = sec_y;
        ppx_d    = v_q;
        load_out = 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid_d = load_out ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpx_q       <= '0;
      tpy_q       <= '0;
      ppx_q       <= '0;
      ppy_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      tpx_q       <= tpx_d;
      tpy_q       <= tpy_d;
      ppx_q       <= ppx_d;
      ppy_q       <= ppy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      x_q <= wave_sample_i;
      n_q <= noise_sample_i;
    end
    p_q   <= prod[ACC_W-1:0];
    acc_q <= acc_d;
    v_q   <= v_d;
    nz_q  <= nz_d;
    m_q   <= m_d;
    if (load_out) begin
      out_q <= sec_y;
    end
  end

  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == rfec_pkg::OP_POUT |=> out_valid_q && out_q == ppy_q)
    else $error("committed result not presented");

endmodule

@@ rtl/receiver_front_end_chain_unit.sv @@
// ----------------------------------------------------------------------------
// receiver_front_end_chain_unit: receiver front-end chain, top level
// Optical or electrical front end, low-pass (optical mode only), variable gain
// and peaking equalizer, one sample pair per transaction, over one multiplier.
// ----------------------------------------------------------------------------
//   channel  direction  payload                        notes
//   cfg_i    sink       index[3:0], data[17:0]         always ready
//   in_i     sink       wave_sample, noise_sample      ready when sequencer idle
//   out_o    source     front_end_out                  registered result
//
// Each transaction is a sequence of dependent operations on the single shared
// multiplier, longer in optical mode; input is taken only while idle.
// A new input transaction is taken while the previous result waits in the
// output register; the sequencer stalls only in its final step if that
// register is still full. Reset presets configuration, clears section state.
// ----------------------------------------------------------------------------
module receiver_front_end_chain_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  rfec_cfg_if.sink    cfg_i,
  rfec_in_if.sink     in_i,
  rfec_out_if.source  out_o
);

  rfec_pkg::cfg_t    cfg;
  rfec_pkg::dp_cmd_t cmd;
  rfec_pkg::dp_sts_t sts;

  rfec_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  rfec_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rfec_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .wave_sample_i   (in_i.wave_sample),
    .noise_sample_i  (in_i.noise_sample),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .front_end_out_o (out_o.front_end_out)
  );

endmodule
